// ===== rtl/core/b2da_pkg.sv =====
// Package for the binary to decimal ASCII converter.
// Holds the shared digit constants, the control state type and the cell control struct.
package b2da_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic dabble;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== rtl/core/b2da_cell.sv =====
// One decimal digit cell of the shift-and-add-3 chain.
// Depends on b2da_pkg for the digit width and the cell control struct.
module b2da_cell (
  input  logic                            clk,
  input  b2da_pkg::cell_ctl_t             ctl,
  input  logic                            bit_in,
  input  logic [b2da_pkg::DIGIT_W-1:0]    dig_in,
  output logic [b2da_pkg::DIGIT_W-1:0]    dig_out,
  output logic                            carry_out
);

  logic [b2da_pkg::DIGIT_W-1:0] dig_r;
  logic [b2da_pkg::DIGIT_W-1:0] dig_nxt;
  logic [b2da_pkg::DIGIT_W-1:0] adj;

  always_comb begin
    adj = (dig_r >= b2da_pkg::DABBLE_LIMIT) ? dig_r + b2da_pkg::DABBLE_ADD : dig_r;
    if (ctl.clear) begin
      dig_nxt = '0;
    end else if (ctl.dabble) begin
      dig_nxt = {adj[b2da_pkg::DIGIT_W-2:0], bit_in};
    end else if (ctl.shift) begin
      dig_nxt = dig_in;
    end else begin
      dig_nxt = dig_r;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end

  assign dig_out   = dig_r;
  assign carry_out = adj[b2da_pkg::DIGIT_W-1];

endmodule

// ===== rtl/core/b2da_chain.sv =====
// Row of decimal digit cells, least significant digit in cell zero.
// Depends on b2da_pkg and b2da_cell.
module b2da_chain #(
  parameter int unsigned NUM_DIGITS = 10
) (
  input  logic                            clk,
  input  b2da_pkg::cell_ctl_t             ctl,
  input  logic                            bit_in,
  output logic [b2da_pkg::DIGIT_W-1:0]    top_digit
);

  logic [b2da_pkg::DIGIT_W-1:0] dig [NUM_DIGITS];
  logic [NUM_DIGITS-1:0]        carry;

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic                         cell_bit;
    logic [b2da_pkg::DIGIT_W-1:0] cell_dig;

    if (i == 0) begin : g_first
      assign cell_bit = bit_in;
      assign cell_dig = '0;
    end else begin : g_rest
      assign cell_bit = carry[i-1];
      assign cell_dig = dig[i-1];
    end

    b2da_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .bit_in    (cell_bit),
      .dig_in    (cell_dig),
      .dig_out   (dig[i]),
      .carry_out (carry[i])
    );
  end

  assign top_digit = dig[NUM_DIGITS-1];

endmodule

// ===== rtl/core/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter: control sequencer and output register.
// Depends on b2da_pkg and b2da_chain.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   input   | in_valid, in_ready, in_value           | in
//   output  | out_valid, out_ready, out_digit_char,  | out
//           | out_last                               |
//
// A request runs shift-and-add-3 through the digit cell row for each of its VALUE_WIDTH bits, then
// steps through each digit position (NUM_DIGITS), leading zeros being dropped one a cycle, and
// returns to idle once the last digit is loaded into the output register.
// The cell row holds one value, so a new request is taken only once the last digit is loaded.
// A stalled output holds the emit phase; reset clears the sequencer and the output valid.
module binary_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [VALUE_WIDTH-1:0]            in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]       out_digit_char,
  output logic                              out_last
);

  localparam int unsigned NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int unsigned BCW        = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned DCW        = $clog2(NUM_DIGITS + 1);

  b2da_pkg::state_t             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0]       shreg_r, shreg_nxt;
  logic [BCW-1:0]               bit_cnt_r, bit_cnt_nxt;
  logic [DCW-1:0]               dig_cnt_r, dig_cnt_nxt;
  logic                         started_r, started_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [b2da_pkg::CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;
  b2da_pkg::cell_ctl_t          ctl;
  logic [b2da_pkg::DIGIT_W-1:0] top_digit;
  logic                         accept;
  logic                         slot_free;
  logic                         is_final;

  b2da_chain #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .bit_in    (shreg_r[VALUE_WIDTH-1]),
    .top_digit (top_digit)
  );

  assign in_ready  = (state_r == b2da_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign is_final  = (dig_cnt_r == DCW'(NUM_DIGITS - 1));

  always_comb begin
    state_nxt     = state_r;
    shreg_nxt     = shreg_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;
    case (state_r)
      b2da_pkg::ST_IDLE: begin
        if (accept) begin
          ctl.clear   = 1'b1;
          shreg_nxt   = in_value;
          bit_cnt_nxt = '0;
          state_nxt   = b2da_pkg::ST_CONV;
        end
      end
      b2da_pkg::ST_CONV: begin
        ctl.dabble  = 1'b1;
        shreg_nxt   = shreg_r << 1;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BCW'(VALUE_WIDTH - 1)) begin
          dig_cnt_nxt = '0;
          started_nxt = 1'b0;
          state_nxt   = b2da_pkg::ST_EMIT;
        end
      end
      b2da_pkg::ST_EMIT: begin
        if (!started_r && top_digit == '0 && !is_final) begin
          ctl.shift   = 1'b1;
          dig_cnt_nxt = dig_cnt_r + 1'b1;
        end else if (slot_free) begin
          ctl.shift     = 1'b1;
          dig_cnt_nxt   = dig_cnt_r + 1'b1;
          started_nxt   = 1'b1;
          out_valid_nxt = 1'b1;
          out_char_nxt  = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(top_digit);
          out_last_nxt  = is_final;
          if (is_final) begin
            state_nxt = b2da_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = b2da_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= b2da_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r    <= shreg_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;

endmodule

// ===== rtl/core/b2da_chk.sv =====
// Port checker for the binary to decimal ASCII converter, bound to the top level.
// Depends on b2da_pkg for the character width.
module b2da_chk #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [VALUE_WIDTH-1:0]       in_value,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [b2da_pkg::CHAR_W-1:0]  out_digit_char,
  input logic                         out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit_char) && $stable(out_last))
    else $error("Stalled result changed.");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit_char >= 6'd48 && out_digit_char <= 6'd57)
    else $error("Result is not a decimal digit character.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("New request taken while a conversion was starting.");

  a_no_request_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |-> !in_ready)
    else $error("Request taken before the last digit of the previous value.");

  a_value_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> $stable(in_value))
    else $error("Pending request changed its value.");

endmodule

bind binary_to_decimal_ascii b2da_chk #(.VALUE_WIDTH(VALUE_WIDTH)) u_b2da_chk (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the binary to decimal ASCII converter.
// It needs b2da_pkg and binary_to_decimal_ascii. It predicts the digit text of each request
// and checks every character and its last flag, with random idling on both channels.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RADIX = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [b2da_pkg::CHAR_W-1:0] ch;
    logic last;
  } digit_exp_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [VALUE_W-1:0] in_value;
  logic out_valid;
  logic out_ready;
  logic [b2da_pkg::CHAR_W-1:0] out_digit_char;
  logic out_last;

  digit_exp_t digits_due[$];
  int unsigned error_count = 0;
  int unsigned values_sent = 0;
  int unsigned digits_checked = 0;
  int unsigned cycle_count = 0;
  bit idle_en = 1'b1;

  binary_to_decimal_ascii #(
    .VALUE_WIDTH(VALUE_W)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_digit_char(out_digit_char),
    .out_last(out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("binary_to_decimal_ascii test failed");
      $finish;
    end
  end

  // Expected characters of one request, most significant digit first.
  function automatic void predict_digits(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] rest;
    logic [3:0] digs[$];
    digit_exp_t item;
    rest = value;
    do begin
      digs.push_front(4'(rest % RADIX));
      rest = rest / RADIX;
    end while (rest != 0);
    foreach (digs[k]) begin
      item.ch = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(digs[k]);
      item.last = (k == digs.size() - 1);
      digits_due.push_back(item);
    end
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    int unsigned bits;
    int unsigned k;
    if ($urandom_range(0, 7) == 0) begin
      v = 1;
      k = $urandom_range(1, 9);
      repeat (k) v = v * RADIX;
      if ($urandom_range(0, 1) == 1) v = v - 1;
    end else begin
      bits = $urandom_range(1, VALUE_W);
      v = $urandom;
      if (bits < VALUE_W) v = v & ((VALUE_W'(1) << bits) - 1);
    end
    return v;
  endfunction

  task automatic send_value(input logic [VALUE_W-1:0] value);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    predict_digits(value);
    values_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The receiver stalls in random bursts while idling is enabled.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (idle_en && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    digit_exp_t exp_digit;
    if (rst_n && out_valid && out_ready) begin
      if (digits_due.size() == 0) begin
        $display("%0t: expected no character, actual %0d last %0b", $time, out_digit_char,
                 out_last);
        error_count++;
      end else begin
        exp_digit = digits_due.pop_front();
        digits_checked++;
        if (out_digit_char !== exp_digit.ch) begin
          $display("%0t: digit_char expected %0d actual %0d", $time, exp_digit.ch,
                   out_digit_char);
          error_count++;
        end
        if (out_last !== exp_digit.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_digit.last, out_last);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed();
    logic [VALUE_W-1:0] edge_values[$];
    edge_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd12345,
                    32'd999999999, 32'd1000000000, 32'd4294967295, 32'd4294967294,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                    32'd0, 32'd4000000000, 32'd65535, 32'd7, 32'd1234567890};
    foreach (edge_values[i]) send_value(edge_values[i]);
    wait_drained();
  endtask

  task automatic test_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      // Idling is switched off for some stretches to run at full rate.
      if (i % 50 == 0) idle_en = ($urandom_range(0, 3) != 0);
      send_value(random_value());
      if (i % 97 == 96) wait_drained();
    end
    idle_en = 1'b1;
  endtask

  task automatic test_full_rate(input int unsigned count);
    idle_en = 1'b0;
    repeat (count) send_value(random_value());
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_full_rate(60);
    wait_drained();
    $display("Converted %0d values and checked %0d characters,", values_sent, digits_checked);
    $display("covering zero, every digit count, both field extremes and random idling.");
    if (error_count == 0) begin
      $display("binary_to_decimal_ascii test passed");
    end else begin
      $display("binary_to_decimal_ascii test failed");
    end
    $finish;
  end

endmodule
